// File: src/h264d_pkg.sv
// Package with sizes, NAL codes, controller states and helpers for the H.264 RTP depacketizer.
package h264d_pkg;

  localparam int FRAME_AW = 16;
  localparam int FRAG_AW = 16;
  localparam int FRAME_DEPTH = 1 << FRAME_AW;
  localparam int FRAG_DEPTH = 1 << FRAG_AW;

  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;
  localparam logic [4:0] NAL_STAP_A = 5'd24;
  localparam logic [4:0] NAL_FU_A = 5'd28;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] AGG_LEN_HI = 2'd0;
  localparam logic [1:0] AGG_LEN_LO = 2'd1;
  localparam logic [1:0] AGG_BODY = 2'd2;
  localparam logic [1:0] AGG_SKIP = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PUT  = 5'b00010,
    ST_COPY = 5'b00100,
    ST_READ = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  function automatic logic single_type(input logic [4:0] t);
    return (t == NAL_SLICE) || (t == NAL_IDR) || (t == NAL_SPS) || (t == NAL_PPS);
  endfunction

endpackage

// File: src/h264_rtp_depacketizer.sv
// H.264 RTP depacketizer that builds an Annex-B frame store from RTP payload bytes.
// A push stores its bytes one by one (up to 5 for a start code and header) and, on an FU-A
// commit, then copies the fragment store into the frame store; a read returns one stored byte.
// One item is in work at a time; the next is taken when the result register is free.
// Each store is a single-port-write memory, so one byte is written per cycle.
// Reset (rst, synchronous) empties both stores and clears all control state.
module h264_rtp_depacketizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0], rtp_seq[23:8], rtp_timestamp[55:24], frame_timestamp[87:56]
  input  logic [87:0] s_axis_tdata,
  // opcode[0], first_byte[1], seq_valid[2], marker[3]
  input  logic [3:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  // out_valid[0], frame_ready[1], packet_dropped[2], overflow[3]
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int FAW = h264d_pkg::FRAME_AW;
  localparam int GAW = h264d_pkg::FRAG_AW;

  logic [7:0] frame_mem [h264d_pkg::FRAME_DEPTH];
  logic [7:0] frag_mem [h264d_pkg::FRAG_DEPTH];
  logic [7:0] frame_q;
  logic [7:0] frag_q;

  h264d_pkg::state_t state;
  logic [FAW-1:0] frame_head;
  logic [FAW:0]   frame_count;
  logic [GAW:0]   frag_count;
  logic [15:0] previous_seq;
  logic [31:0] previous_timestamp;
  logic [15:0] byte_position;
  logic [4:0]  unit_type;
  logic        drop_packet;
  logic [1:0]  indicator_nri;
  logic        fragment_end_seen;
  logic [1:0]  aggregate_phase;
  logic [15:0] aggregate_length;
  logic [15:0] aggregate_remaining;
  logic        aggregate_keep;
  logic        overflow_flag;

  logic [7:0] pend [5];
  logic [2:0] pend_n;
  logic [2:0] pend_idx;
  logic       pend_frag;
  logic       commit;
  logic       ready_req;
  logic       dropped;
  logic [GAW:0] cp_rd;
  logic       cp_v;

  logic [7:0]  in_byte;
  logic [15:0] in_seq;
  logic [31:0] in_rts;
  logic [31:0] in_fts;
  logic        in_op;
  logic        in_first;
  logic        in_seq_ok;
  logic        in_mark;
  logic        accept;
  logic        out_free;

  assign in_byte = s_axis_tdata[7:0];
  assign in_seq = s_axis_tdata[23:8];
  assign in_rts = s_axis_tdata[55:24];
  assign in_fts = s_axis_tdata[87:56];
  assign in_op = s_axis_tuser[0];
  assign in_first = s_axis_tuser[1];
  assign in_seq_ok = s_axis_tuser[2];
  assign in_mark = s_axis_tuser[3];

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == h264d_pkg::ST_IDLE) && out_free;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Decode of one push byte.
  logic [4:0]  t_in;
  logic        gap;
  logic        drop_eff;
  logic [7:0]  d_pend [5];
  logic [2:0]  d_n;
  logic        d_frag;
  logic        d_commit;
  logic        es_eff;
  logic [15:0] len_lo;
  logic        agg_first;
  logic        keep_eff;

  always_comb begin
    t_in = in_byte[4:0];
    gap = in_seq_ok && (previous_seq != 16'd0) && ((previous_seq + 16'd1) != in_seq)
          && (t_in != h264d_pkg::NAL_SPS);
    drop_eff = in_first ? gap : drop_packet;
    d_pend[0] = 8'h00;
    d_pend[1] = 8'h00;
    d_pend[2] = 8'h00;
    d_pend[3] = 8'h01;
    d_pend[4] = in_byte;
    d_n = 3'd0;
    d_frag = 1'b0;
    d_commit = 1'b0;
    es_eff = (byte_position == 16'd1) ? in_byte[6] : fragment_end_seen;
    len_lo = {aggregate_length[15:8], in_byte};
    agg_first = (aggregate_remaining == aggregate_length);
    keep_eff = agg_first ? h264d_pkg::single_type(in_byte[4:0]) : aggregate_keep;
    if (in_first) begin
      if (!gap && h264d_pkg::single_type(t_in)) begin
        d_n = 3'd5;
      end
    end else if (!drop_packet) begin
      if (h264d_pkg::single_type(unit_type)) begin
        d_n = 3'd1;
        d_pend[0] = in_byte;
      end else if (unit_type == h264d_pkg::NAL_FU_A) begin
        d_frag = 1'b1;
        if (byte_position == 16'd1) begin
          if (in_byte[7]) begin
            d_n = 3'd5;
            d_pend[4] = {1'b0, indicator_nri, in_byte[4:0]};
          end
        end else begin
          d_n = 3'd1;
          d_pend[0] = in_byte;
        end
        d_commit = s_axis_tlast && es_eff;
      end else if (unit_type == h264d_pkg::NAL_STAP_A) begin
        if (aggregate_phase == h264d_pkg::AGG_BODY && keep_eff) begin
          if (agg_first) begin
            d_n = 3'd5;
          end else begin
            d_n = 3'd1;
            d_pend[0] = in_byte;
          end
        end
      end
    end
  end

  // Store write ports.
  logic           fw_en;
  logic [FAW-1:0] fw_addr;
  logic [7:0]     fw_data;
  logic           gw_en;
  logic           put_frame;
  logic           put_frag;
  logic [FAW:0]   tail_sum;

  always_comb begin
    put_frame = ((state == h264d_pkg::ST_PUT) && !pend_frag) ||
                ((state == h264d_pkg::ST_COPY) && cp_v);
    put_frag = (state == h264d_pkg::ST_PUT) && pend_frag;
    fw_data = (state == h264d_pkg::ST_COPY) ? frag_q : pend[pend_idx];
    fw_en = put_frame && !frame_count[FAW];
    gw_en = put_frag && !frag_count[GAW];
    tail_sum = {1'b0, frame_head} + frame_count;
    fw_addr = tail_sum[FAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (fw_en) begin
      frame_mem[fw_addr] <= fw_data;
    end
    frame_q <= frame_mem[frame_head];
  end

  always_ff @(posedge clk) begin
    if (gw_en) begin
      frag_mem[frag_count[GAW-1:0]] <= pend[pend_idx];
    end
    frag_q <= frag_mem[cp_rd[GAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= h264d_pkg::ST_IDLE;
      frame_head <= '0;
      frame_count <= '0;
      frag_count <= '0;
      previous_seq <= '0;
      previous_timestamp <= '0;
      byte_position <= '0;
      unit_type <= '0;
      drop_packet <= 1'b0;
      indicator_nri <= '0;
      fragment_end_seen <= 1'b0;
      aggregate_phase <= h264d_pkg::AGG_LEN_HI;
      aggregate_length <= '0;
      aggregate_remaining <= '0;
      aggregate_keep <= 1'b0;
      overflow_flag <= 1'b0;
      pend_n <= '0;
      pend_idx <= '0;
      pend_frag <= 1'b0;
      commit <= 1'b0;
      ready_req <= 1'b0;
      dropped <= 1'b0;
      cp_rd <= '0;
      cp_v <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tuser <= '0;
      m_axis_tlast <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (put_frame) begin
        if (frame_count[FAW]) begin
          overflow_flag <= 1'b1;
        end else begin
          frame_count <= frame_count + 1'b1;
        end
      end
      if (put_frag) begin
        if (frag_count[GAW]) begin
          overflow_flag <= 1'b1;
        end else begin
          frag_count <= frag_count + 1'b1;
        end
      end
      unique case (state)
        h264d_pkg::ST_IDLE: begin
          if (accept && in_op == h264d_pkg::OP_READ) begin
            state <= h264d_pkg::ST_READ;
          end else if (accept) begin
            pend <= d_pend;
            pend_n <= d_n;
            pend_idx <= (d_n == 3'd1) ? 3'd0 : 3'd0;
            pend_frag <= d_frag;
            commit <= d_commit;
            dropped <= drop_eff;
            ready_req <= s_axis_tlast && !drop_eff && in_mark;
            if (d_n != 3'd0) begin
              state <= h264d_pkg::ST_PUT;
            end else if (d_commit) begin
              state <= h264d_pkg::ST_COPY;
            end else begin
              state <= h264d_pkg::ST_DONE;
            end
            cp_rd <= '0;
            cp_v <= 1'b0;
            if (in_first) begin
              unit_type <= t_in;
              drop_packet <= gap;
              if (gap || (previous_timestamp != in_fts)) begin
                frame_head <= '0;
                frame_count <= '0;
                frag_count <= '0;
              end
              if (gap) begin
                previous_timestamp <= in_rts;
                previous_seq <= in_seq;
              end else begin
                previous_timestamp <= in_fts;
                previous_seq <= in_seq_ok ? in_seq : 16'd0;
                if (t_in == h264d_pkg::NAL_FU_A) begin
                  indicator_nri <= in_byte[6:5];
                  fragment_end_seen <= 1'b0;
                end else if (t_in == h264d_pkg::NAL_STAP_A) begin
                  aggregate_phase <= h264d_pkg::AGG_LEN_HI;
                  aggregate_length <= '0;
                  aggregate_remaining <= '0;
                  aggregate_keep <= 1'b0;
                end
              end
            end else if (!drop_packet) begin
              if (unit_type == h264d_pkg::NAL_FU_A && byte_position == 16'd1) begin
                fragment_end_seen <= in_byte[6];
              end else if (unit_type == h264d_pkg::NAL_STAP_A) begin
                unique case (aggregate_phase)
                  h264d_pkg::AGG_LEN_HI: begin
                    aggregate_length <= {in_byte, 8'h00};
                    aggregate_phase <= h264d_pkg::AGG_LEN_LO;
                  end
                  h264d_pkg::AGG_LEN_LO: begin
                    aggregate_length <= len_lo;
                    if (len_lo == 16'd0) begin
                      aggregate_phase <= h264d_pkg::AGG_SKIP;
                    end else begin
                      aggregate_remaining <= len_lo;
                      aggregate_keep <= 1'b0;
                      aggregate_phase <= h264d_pkg::AGG_BODY;
                    end
                  end
                  h264d_pkg::AGG_BODY: begin
                    aggregate_keep <= keep_eff;
                    aggregate_remaining <= aggregate_remaining - 16'd1;
                    if (aggregate_remaining == 16'd1) begin
                      aggregate_phase <= h264d_pkg::AGG_LEN_HI;
                    end
                  end
                  default: begin
                    aggregate_phase <= h264d_pkg::AGG_LEN_HI;
                  end
                endcase
              end
            end
            if (in_first) begin
              byte_position <= 16'd1;
            end else if (byte_position != 16'hffff) begin
              byte_position <= byte_position + 16'd1;
            end
            if (s_axis_tlast) begin
              unit_type <= '0;
              drop_packet <= 1'b0;
            end
          end
        end
        h264d_pkg::ST_PUT: begin
          if (pend_n == 3'd5 && pend_idx != 3'd4) begin
            pend_idx <= pend_idx + 3'd1;
          end else if (commit) begin
            state <= h264d_pkg::ST_COPY;
          end else begin
            state <= h264d_pkg::ST_DONE;
          end
        end
        h264d_pkg::ST_COPY: begin
          if (cp_rd < frag_count) begin
            cp_rd <= cp_rd + 1'b1;
            cp_v <= 1'b1;
          end else begin
            cp_v <= 1'b0;
            if (!cp_v) begin
              frag_count <= '0;
              state <= h264d_pkg::ST_DONE;
            end
          end
        end
        h264d_pkg::ST_READ: begin
          if (out_free) begin
            state <= h264d_pkg::ST_IDLE;
            m_axis_tvalid <= 1'b1;
            if (frame_count != '0) begin
              m_axis_tdata <= frame_q;
              m_axis_tuser <= {overflow_flag, 2'b00, 1'b1};
              m_axis_tlast <= (frame_count == {{FAW{1'b0}}, 1'b1});
              frame_head <= frame_head + 1'b1;
              frame_count <= frame_count - 1'b1;
            end else begin
              m_axis_tdata <= '0;
              m_axis_tuser <= {overflow_flag, 3'b000};
              m_axis_tlast <= 1'b0;
            end
          end
        end
        h264d_pkg::ST_DONE: begin
          if (out_free) begin
            state <= h264d_pkg::ST_IDLE;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= '0;
            m_axis_tlast <= 1'b0;
            m_axis_tuser <= {overflow_flag, dropped,
                             ready_req && (frame_count != '0), 1'b0};
          end
        end
        default: begin
          state <= h264d_pkg::ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= (FAW+1)'(h264d_pkg::FRAME_DEPTH))
    else $error("frame store count beyond depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    fw_en |-> !frame_count[FAW])
    else $error("frame store written while full");

  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    (state == h264d_pkg::ST_COPY) |-> (cp_rd <= frag_count))
    else $error("fragment copy ran past fill");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == h264d_pkg::ST_IDLE))
    else $error("input taken while busy");

endmodule
